// ----- design/gtl_pkg.sv -----
// Shared types, character codes and byte classifiers for the grammar token lexer.
package gtl_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int RESULT_DEPTH        = 4;

  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] TOK_COMMENT   = 4'd0;
  localparam logic [3:0] TOK_SPACE     = 4'd1;
  localparam logic [3:0] TOK_STRING    = 4'd2;
  localparam logic [3:0] TOK_CHAR      = 4'd3;
  localparam logic [3:0] TOK_IDENT     = 4'd4;
  localparam logic [3:0] TOK_DEFINE    = 4'd5;
  localparam logic [3:0] TOK_TERMINATE = 4'd6;
  localparam logic [3:0] TOK_OPEN      = 4'd7;
  localparam logic [3:0] TOK_CLOSE     = 4'd8;
  localparam logic [3:0] TOK_RANGE     = 4'd9;
  localparam logic [3:0] TOK_SOLID     = 4'd10;
  localparam logic [3:0] TOK_HOLLOW    = 4'd11;
  localparam logic [3:0] TOK_OPTION    = 4'd12;
  localparam logic [3:0] TOK_FINITE    = 4'd13;
  localparam logic [3:0] TOK_ALTERNATE = 4'd14;

  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_EQUAL     = 8'h3D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_UNDER     = 8'h5F;

  typedef enum logic [9:0] {
    MODE_IDLE     = 10'b00_0000_0001,
    MODE_SPACE    = 10'b00_0000_0010,
    MODE_IDENT    = 10'b00_0000_0100,
    MODE_CMT_OPEN = 10'b00_0000_1000,
    MODE_CMT_BODY = 10'b00_0001_0000,
    MODE_STRING   = 10'b00_0010_0000,
    MODE_CHAR     = 10'b00_0100_0000,
    MODE_DEFINE   = 10'b00_1000_0000,
    MODE_RANGE    = 10'b01_0000_0000,
    MODE_FINITE   = 10'b10_0000_0000
  } mode_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  token_type;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_result;
  } result_t;

  typedef struct packed {
    mode_t      mode;
    logic       single;
    logic [3:0] ttype;
    logic       bad;
  } opener_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b >= 8'h09 && b <= 8'h0D) || b == 8'h20;
  endfunction

  function automatic logic is_ident_head(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // What a byte opens when no token is in progress.
  function automatic opener_t classify(input logic [7:0] b);
    opener_t o;
    o.mode   = MODE_IDLE;
    o.single = 1'b0;
    o.ttype  = TOK_COMMENT;
    o.bad    = 1'b0;
    priority if (b == CH_SLASH)   o.mode = MODE_CMT_OPEN;
    else if (is_space(b))         o.mode = MODE_SPACE;
    else if (b == CH_DQUOTE)      o.mode = MODE_STRING;
    else if (b == CH_SQUOTE)      o.mode = MODE_CHAR;
    else if (is_ident_head(b))    o.mode = MODE_IDENT;
    else if (b == CH_COLON)       o.mode = MODE_DEFINE;
    else if (b == CH_SEMI)     begin o.single = 1'b1; o.ttype = TOK_TERMINATE; end
    else if (b == CH_LPAREN)   begin o.single = 1'b1; o.ttype = TOK_OPEN;      end
    else if (b == CH_RPAREN)   begin o.single = 1'b1; o.ttype = TOK_CLOSE;     end
    else if (b == CH_DOT)         o.mode = MODE_RANGE;
    else if (b == CH_PLUS)     begin o.single = 1'b1; o.ttype = TOK_SOLID;     end
    else if (b == CH_STAR)     begin o.single = 1'b1; o.ttype = TOK_HOLLOW;    end
    else if (b == CH_QUESTION) begin o.single = 1'b1; o.ttype = TOK_OPTION;    end
    else if (b == CH_LBRACE)      o.mode = MODE_FINITE;
    else if (b == CH_BAR)      begin o.single = 1'b1; o.ttype = TOK_ALTERNATE; end
    else                          o.bad = 1'b1;
    return o;
  endfunction

endpackage

// ----- design/gtl_text_if.sv -----
// Byte channel into the lexer.
interface gtl_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source(output valid, output data_byte, output end_of_input, input ready);
  modport sink(input valid, input data_byte, input end_of_input, output ready);
endinterface

// ----- design/gtl_token_if.sv -----
// Result channel out of the lexer.
interface gtl_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  token_type;
  logic [31:0] token_start;
  logic [31:0] token_length;
  logic        last_result;

  modport source(output valid, output result_kind, output token_type, output token_start,
                 output token_length, output last_result, input ready);
  modport sink(input valid, input result_kind, input token_type, input token_start,
               input token_length, input last_result, output ready);
endinterface

// ----- design/grammar_token_lexer.sv -----
// Grammar token lexer top level: scan state, token decisions and result queue.
//
//  channel | dir | handshake     | payload
//  text    | in  | valid/ready   | data_byte[7:0], end_of_input
//  tokens  | out | valid/ready   | result_kind, token_type, token_start, token_length,
//          |     |               | last_result
//
// One byte is taken per cycle; the scan state updates at the transfer edge and its
// zero, one or two results enter a four-entry queue that drives the tokens channel.
// text.ready is high while the queue has room for two results, so a byte is taken
// each cycle unless the sink stalls or two-result bytes arrive faster than it drains.
// Synchronous reset clears the scan state and empties the queue.
module grammar_token_lexer #(
  parameter int OFFSET_BITS = gtl_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  gtl_text_if.sink     text,
  gtl_token_if.source  tokens
);

  localparam int OB = OFFSET_BITS;

  gtl_pkg::mode_t   mode, mode_next;
  logic [1:0]       sub_step, sub_step_next;
  logic             star_seen, star_seen_next;
  logic             escape_parity, escape_parity_next;
  logic             halted, halted_next;
  logic [OB-1:0]    pos, pos_next;
  logic [OB-1:0]    cur_start, cur_start_next;

  logic [OB-1:0]    cur_pos, after;
  logic             accept, room, lead_v, tail_v, open_tok;
  logic [7:0]       b, quote;
  gtl_pkg::opener_t cls;
  gtl_pkg::result_t lead, tail, slot0, slot1;
  logic [1:0]       push_n;

  function automatic logic [31:0] sat32(input logic [OB-1:0] v);
    logic [OB+31:0] w;
    w = {32'b0, v};
    return (|w[OB+31:32]) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic gtl_pkg::result_t make_result(input logic [1:0] kind,
                                                   input logic [3:0] ttype,
                                                   input logic [OB-1:0] start,
                                                   input logic [OB-1:0] len);
    gtl_pkg::result_t r;
    r.result_kind  = kind;
    r.token_type   = ttype;
    r.token_start  = sat32(start);
    r.token_length = sat32(len);
    r.last_result  = 1'b0;
    return r;
  endfunction

  assign accept  = text.valid && text.ready;
  assign b       = text.data_byte;
  assign cur_pos = pos;
  assign after   = (pos == '1) ? pos : pos + 1'b1;
  assign cls     = gtl_pkg::classify(b);
  assign quote   = (mode == gtl_pkg::MODE_STRING) ? gtl_pkg::CH_DQUOTE : gtl_pkg::CH_SQUOTE;

  always_comb begin
    mode_next          = mode;
    sub_step_next      = sub_step;
    star_seen_next     = star_seen;
    escape_parity_next = escape_parity;
    halted_next        = halted;
    pos_next           = pos;
    cur_start_next     = cur_start;
    lead_v             = 1'b0;
    tail_v             = 1'b0;
    lead               = '0;
    tail               = '0;
    open_tok           = 1'b0;
    if (accept) begin
      if (text.end_of_input) begin
        if (!halted) begin
          tail_v = 1'b1;
          if (mode == gtl_pkg::MODE_SPACE || mode == gtl_pkg::MODE_IDENT) begin
            lead_v = 1'b1;
            lead   = make_result(gtl_pkg::KIND_TOKEN,
                                 (mode == gtl_pkg::MODE_SPACE) ? gtl_pkg::TOK_SPACE
                                                               : gtl_pkg::TOK_IDENT,
                                 cur_start, pos - cur_start);
            tail   = make_result(gtl_pkg::KIND_END, gtl_pkg::TOK_COMMENT, pos, '0);
          end else if (mode != gtl_pkg::MODE_IDLE) begin
            tail = make_result(gtl_pkg::KIND_ERROR, gtl_pkg::TOK_COMMENT, cur_start, '0);
          end else begin
            tail = make_result(gtl_pkg::KIND_END, gtl_pkg::TOK_COMMENT, pos, '0);
          end
        end
        mode_next          = gtl_pkg::MODE_IDLE;
        sub_step_next      = '0;
        star_seen_next     = 1'b0;
        escape_parity_next = 1'b0;
        halted_next        = 1'b0;
        pos_next           = '0;
        cur_start_next     = '0;
      end else if (!halted) begin
        pos_next = after;
        unique case (mode)
          gtl_pkg::MODE_SPACE: begin
            if (!gtl_pkg::is_space(b)) begin
              lead_v   = 1'b1;
              lead     = make_result(gtl_pkg::KIND_TOKEN, gtl_pkg::TOK_SPACE,
                                     cur_start, cur_pos - cur_start);
              open_tok = 1'b1;
            end
          end
          gtl_pkg::MODE_IDENT: begin
            if (!(gtl_pkg::is_ident_head(b) || gtl_pkg::is_digit(b))) begin
              lead_v   = 1'b1;
              lead     = make_result(gtl_pkg::KIND_TOKEN, gtl_pkg::TOK_IDENT,
                                     cur_start, cur_pos - cur_start);
              open_tok = 1'b1;
            end
          end
          gtl_pkg::MODE_CMT_OPEN: begin
            if (b == gtl_pkg::CH_STAR) begin
              mode_next      = gtl_pkg::MODE_CMT_BODY;
              star_seen_next = 1'b0;
            end else begin
              tail_v      = 1'b1;
              tail        = make_result(gtl_pkg::KIND_ERROR, gtl_pkg::TOK_COMMENT,
                                        cur_start, '0);
              halted_next = 1'b1;
              mode_next   = gtl_pkg::MODE_IDLE;
            end
          end
          gtl_pkg::MODE_CMT_BODY: begin
            if (star_seen && b == gtl_pkg::CH_SLASH) begin
              tail_v    = 1'b1;
              tail      = make_result(gtl_pkg::KIND_TOKEN, gtl_pkg::TOK_COMMENT,
                                      cur_start, after - cur_start);
              mode_next = gtl_pkg::MODE_IDLE;
            end else begin
              star_seen_next = b == gtl_pkg::CH_STAR;
            end
          end
          gtl_pkg::MODE_STRING, gtl_pkg::MODE_CHAR: begin
            if (b == gtl_pkg::CH_BACKSLASH) begin
              escape_parity_next = ~escape_parity;
            end else if (b == quote && !escape_parity) begin
              tail_v    = 1'b1;
              tail      = make_result(gtl_pkg::KIND_TOKEN,
                                      (mode == gtl_pkg::MODE_STRING) ? gtl_pkg::TOK_STRING
                                                                     : gtl_pkg::TOK_CHAR,
                                      cur_start, after - cur_start);
              mode_next = gtl_pkg::MODE_IDLE;
            end else begin
              escape_parity_next = 1'b0;
            end
          end
          gtl_pkg::MODE_DEFINE: begin
            tail_v    = 1'b1;
            mode_next = gtl_pkg::MODE_IDLE;
            if (b == gtl_pkg::CH_EQUAL) begin
              tail = make_result(gtl_pkg::KIND_TOKEN, gtl_pkg::TOK_DEFINE,
                                 cur_start, after - cur_start);
            end else begin
              tail        = make_result(gtl_pkg::KIND_ERROR, gtl_pkg::TOK_COMMENT,
                                        cur_start, '0);
              halted_next = 1'b1;
            end
          end
          gtl_pkg::MODE_RANGE: begin
            if (b != gtl_pkg::CH_DOT) begin
              tail_v      = 1'b1;
              tail        = make_result(gtl_pkg::KIND_ERROR, gtl_pkg::TOK_COMMENT,
                                        cur_start, '0);
              halted_next = 1'b1;
              mode_next   = gtl_pkg::MODE_IDLE;
            end else if (sub_step >= 2'd2) begin
              sub_step_next = '0;
              tail_v        = 1'b1;
              tail          = make_result(gtl_pkg::KIND_TOKEN, gtl_pkg::TOK_RANGE,
                                          cur_start, after - cur_start);
              mode_next     = gtl_pkg::MODE_IDLE;
            end else begin
              sub_step_next = sub_step + 1'b1;
            end
          end
          gtl_pkg::MODE_FINITE: begin
            if (!gtl_pkg::is_digit(b)) begin
              tail_v    = 1'b1;
              mode_next = gtl_pkg::MODE_IDLE;
              if (b == gtl_pkg::CH_RBRACE) begin
                tail = make_result(gtl_pkg::KIND_TOKEN, gtl_pkg::TOK_FINITE,
                                   cur_start, after - cur_start);
              end else begin
                tail        = make_result(gtl_pkg::KIND_ERROR, gtl_pkg::TOK_COMMENT,
                                          cur_start, '0);
                halted_next = 1'b1;
              end
            end
          end
          default: open_tok = 1'b1;
        endcase

        if (open_tok) begin
          cur_start_next = cur_pos;
          mode_next      = gtl_pkg::MODE_IDLE;
          if (cls.bad) begin
            tail_v      = 1'b1;
            tail        = make_result(gtl_pkg::KIND_ERROR, gtl_pkg::TOK_COMMENT, cur_pos, '0);
            halted_next = 1'b1;
          end else if (cls.single) begin
            tail_v = 1'b1;
            tail   = make_result(gtl_pkg::KIND_TOKEN, cls.ttype, cur_pos, after - cur_pos);
          end else begin
            mode_next = cls.mode;
            if (cls.mode == gtl_pkg::MODE_STRING || cls.mode == gtl_pkg::MODE_CHAR)
              escape_parity_next = 1'b0;
            if (cls.mode == gtl_pkg::MODE_RANGE)
              sub_step_next = 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    slot0             = lead_v ? lead : tail;
    slot0.last_result = !(lead_v && tail_v);
    slot1             = tail;
    slot1.last_result = 1'b1;
    push_n            = {1'b0, lead_v} + {1'b0, tail_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= gtl_pkg::MODE_IDLE;
      sub_step      <= '0;
      star_seen     <= 1'b0;
      escape_parity <= 1'b0;
      halted        <= 1'b0;
      pos           <= '0;
      cur_start     <= '0;
    end else begin
      mode          <= mode_next;
      sub_step      <= sub_step_next;
      star_seen     <= star_seen_next;
      escape_parity <= escape_parity_next;
      halted        <= halted_next;
      pos           <= pos_next;
      cur_start     <= cur_start_next;
    end
  end

  assign text.ready = room;

  gtl_result_queue #(
    .DEPTH(gtl_pkg::RESULT_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push_n(push_n),
    .slot0 (slot0),
    .slot1 (slot1),
    .room  (room),
    .tokens(tokens)
  );

endmodule

// ----- design/gtl_result_queue.sv -----
// Result queue: takes up to two results per cycle, drives one per transfer.
module gtl_result_queue #(
  parameter int DEPTH = gtl_pkg::RESULT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  gtl_pkg::result_t  slot0,
  input  gtl_pkg::result_t  slot1,
  output logic              room,
  gtl_token_if.source       tokens
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  gtl_pkg::result_t entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr_inc;
  logic [CW-1:0] count, count_next;
  logic          pop;
  gtl_pkg::result_t head;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_inc = wrap_inc(wr_ptr);
  assign pop        = tokens.valid && tokens.ready;
  assign room       = count <= CW'(DEPTH - 2);
  assign count_next = count + CW'(push_n) - CW'(pop);
  assign head       = entries[rd_ptr];

  assign tokens.valid        = count != '0;
  assign tokens.result_kind  = head.result_kind;
  assign tokens.token_type   = head.token_type;
  assign tokens.token_start  = head.token_start;
  assign tokens.token_length = head.token_length;
  assign tokens.last_result  = head.last_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) rd_ptr <= wrap_inc(rd_ptr);
      unique case (push_n)
        2'd1:    wr_ptr <= wr_ptr_inc;
        2'd2:    wr_ptr <= wrap_inc(wr_ptr_inc);
        default: wr_ptr <= wr_ptr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries[wr_ptr] <= slot0;
    if (push_n == 2'd2) entries[wr_ptr_inc] <= slot1;
  end

endmodule

// ----- design/gtl_checker.sv -----
// Port-level checks on the lexer's result channel, bound to the top level.
module gtl_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [1:0]  result_kind,
  input logic [3:0]  token_type,
  input logic [31:0] token_start,
  input logic [31:0] token_length,
  input logic        last_result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(result_kind) && $stable(token_type) &&
                        $stable(token_start) && $stable(token_length) &&
                        $stable(last_result))
    else $error("stalled transfer changed");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    valid && result_kind != gtl_pkg::KIND_TOKEN |-> token_type == '0 && token_length == '0)
    else $error("end or error result carries token fields");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    valid && result_kind != gtl_pkg::KIND_TOKEN |-> last_result)
    else $error("end or error result not final for its byte");

endmodule

bind grammar_token_lexer gtl_checker u_gtl_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (tokens.valid),
  .ready       (tokens.ready),
  .result_kind (tokens.result_kind),
  .token_type  (tokens.token_type),
  .token_start (tokens.token_start),
  .token_length(tokens.token_length),
  .last_result (tokens.last_result)
);
